// ===== rtl/mst_pkg.sv =====
// ----------------------------------------------------------------------------
// mst_pkg
// Shared types and constants for the minimum spanning tree unit.
// ----------------------------------------------------------------------------
package mst_pkg;

  localparam int VERT_BITS        = 6;
  localparam int VERT_SLOTS       = 64;
  localparam int WEIGHT_BITS      = 32;
  localparam int DEF_MAX_VERTICES = 64;
  localparam int DEF_MAX_EDGES    = 256;

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_COMPUTE = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_NONE    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INIT,
    ST_SCAN,
    ST_DECIDE
  } state_t;

  typedef struct packed {
    logic [VERT_BITS-1:0]          a;
    logic [VERT_BITS-1:0]          b;
    logic signed [WEIGHT_BITS-1:0] w;
  } edge_t;

endpackage

// ===== rtl/minimum_spanning_tree_unit.sv =====
// ----------------------------------------------------------------------------
// minimum_spanning_tree_unit
// Edge store plus a Prim engine that scans the store once per tree edge.
// ----------------------------------------------------------------------------
// An add or clear item leaves busy low. A compute item runs one scan of
// the edge store for each vertex joined to the tree, plus one final scan
// that finds nothing; the single compare unit looks at one stored edge a
// cycle. Results come out on result_valid for one cycle each and cannot be
// stalled; a result is held back one scan so that the final one can carry
// last_edge. An add to a full store gives one result with store_full set.
module minimum_spanning_tree_unit #(
  parameter int MAX_VERTICES = mst_pkg::DEF_MAX_VERTICES,
  parameter int MAX_EDGES    = mst_pkg::DEF_MAX_EDGES
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 cfg_we,
  input  logic [6:0]                           cfg_wdata,
  input  logic [1:0]                           opcode,
  input  logic [mst_pkg::VERT_BITS-1:0]        vertex_a,
  input  logic [mst_pkg::VERT_BITS-1:0]        vertex_b,
  input  logic signed [mst_pkg::WEIGHT_BITS-1:0] edge_weight,
  output logic                                 result_valid,
  output logic [mst_pkg::VERT_BITS-1:0]        from_vertex,
  output logic [mst_pkg::VERT_BITS-1:0]        to_vertex,
  output logic signed [mst_pkg::WEIGHT_BITS-1:0] tree_weight,
  output logic                                 edge_valid,
  output logic                                 last_edge,
  output logic                                 store_full
);
  import mst_pkg::*;

  localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int TW = $clog2(MAX_EDGES + 1);

  state_t state, state_next;

  logic [6:0]           vertex_count;
  logic [6:0]           n_eff;
  logic [TW-1:0]        edge_total;
  edge_t                edge_mem [MAX_EDGES];
  logic [VERT_BITS-1:0] rank_mem [VERT_SLOTS];
  logic [VERT_SLOTS-1:0] visited;
  logic [VERT_BITS-1:0] rank_cnt;

  logic [TW-1:0]        rd_addr;
  edge_t                e_q;
  logic                 s1_v;
  logic                 s2_v, s2_elig;
  logic [VERT_BITS-1:0] s2_from, s2_to, rank_q;
  logic signed [WEIGHT_BITS-1:0] s2_w;

  logic                 best_found;
  logic [VERT_BITS-1:0] best_from, best_to, best_rank;
  logic signed [WEIGHT_BITS-1:0] best_w;

  logic                 pend_v;
  logic [VERT_BITS-1:0] pend_from, pend_to;
  logic signed [WEIGHT_BITS-1:0] pend_w;

  logic accept, do_issue, scan_done;
  logic in_a, in_b, va, vb, s1_elig, better;
  logic [VERT_BITS-1:0] s1_from, s1_to;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);

  always_comb begin
    if (vertex_count == 7'd0) n_eff = 7'd1;
    else if (vertex_count > 7'(MAX_VERTICES)) n_eff = 7'(MAX_VERTICES);
    else n_eff = vertex_count;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (accept && opcode_t'(opcode) == OP_COMPUTE) state_next = ST_INIT;
      ST_INIT:   state_next = ST_SCAN;
      ST_SCAN:   if (scan_done) state_next = ST_DECIDE;
      ST_DECIDE: state_next = best_found ? ST_SCAN : ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    do_issue  = 1'b0;
    scan_done = 1'b0;
    unique case (state)
      ST_SCAN: begin
        do_issue  = (rd_addr < edge_total);
        scan_done = !do_issue && !s1_v && !s2_v;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // edge store
  always_ff @(posedge clk) begin
    if (accept && opcode_t'(opcode) == OP_ADD && edge_total < TW'(MAX_EDGES))
      edge_mem[edge_total[EW-1:0]] <= '{a: vertex_a, b: vertex_b, w: edge_weight};
    if (do_issue) e_q <= edge_mem[rd_addr[EW-1:0]];
  end

  // stage one: direction and eligibility
  always_comb begin
    in_a    = {1'b0, e_q.a} < n_eff;
    in_b    = {1'b0, e_q.b} < n_eff;
    va      = visited[e_q.a];
    vb      = visited[e_q.b];
    s1_elig = in_a && in_b && (va != vb);
    s1_from = va ? e_q.a : e_q.b;
    s1_to   = va ? e_q.b : e_q.a;
  end

  always_ff @(posedge clk) begin
    rank_q <= rank_mem[s1_from];
    if (state == ST_INIT) rank_mem[0] <= '0;
    else if (state == ST_DECIDE && best_found) rank_mem[best_to] <= rank_cnt;
  end

  // ties keep the earlier-ranked tree vertex, then the lower edge index
  always_comb begin
    better = s2_v && s2_elig &&
             (!best_found || s2_w < best_w || (s2_w == best_w && rank_q < best_rank));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= 7'd1;
      edge_total   <= '0;
      s1_v         <= 1'b0;
      s2_v         <= 1'b0;
      best_found   <= 1'b0;
      pend_v       <= 1'b0;
      result_valid <= 1'b0;
      visited      <= '0;
      rank_cnt     <= '0;
      rd_addr      <= '0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_we) vertex_count <= cfg_wdata;
      s1_v    <= do_issue;
      s2_v    <= s1_v;
      s2_elig <= s1_elig;
      s2_from <= s1_from;
      s2_to   <= s1_to;
      s2_w    <= e_q.w;
      if (do_issue) rd_addr <= rd_addr + TW'(1);
      if (better) begin
        best_found <= 1'b1;
        best_from  <= s2_from;
        best_to    <= s2_to;
        best_w     <= s2_w;
        best_rank  <= rank_q;
      end
      if (accept) begin
        case (opcode_t'(opcode))
          OP_ADD: begin
            if (edge_total < TW'(MAX_EDGES)) begin
              edge_total <= edge_total + TW'(1);
            end else begin
              result_valid <= 1'b1;
              from_vertex  <= '0;
              to_vertex    <= '0;
              tree_weight  <= '0;
              edge_valid   <= 1'b0;
              last_edge    <= 1'b0;
              store_full   <= 1'b1;
            end
          end
          OP_CLEAR: edge_total <= '0;
          default: ;
        endcase
      end
      if (state == ST_INIT) begin
        visited    <= VERT_SLOTS'(1);
        rank_cnt   <= VERT_BITS'(1);
        rd_addr    <= '0;
        best_found <= 1'b0;
        pend_v     <= 1'b0;
      end
      if (state == ST_DECIDE) begin
        rd_addr    <= '0;
        best_found <= 1'b0;
        store_full <= 1'b0;
        if (best_found) begin
          visited[best_to] <= 1'b1;
          rank_cnt  <= rank_cnt + VERT_BITS'(1);
          pend_v    <= 1'b1;
          pend_from <= best_from;
          pend_to   <= best_to;
          pend_w    <= best_w;
          if (pend_v) begin
            result_valid <= 1'b1;
            from_vertex  <= pend_from;
            to_vertex    <= pend_to;
            tree_weight  <= pend_w;
            edge_valid   <= 1'b1;
            last_edge    <= 1'b0;
          end
        end else begin
          // final item of the compute: held edge, or an empty marker
          result_valid <= 1'b1;
          from_vertex  <= pend_v ? pend_from : '0;
          to_vertex    <= pend_v ? pend_to : '0;
          tree_weight  <= pend_v ? pend_w : '0;
          edge_valid   <= pend_v;
          last_edge    <= 1'b1;
          pend_v       <= 1'b0;
        end
      end
    end
  end

endmodule
